/* design/radix_integer_to_digits_assert.svh */
// Assertion macros for the radix conversion RTL.
`ifndef RADIX_INTEGER_TO_DIGITS_ASSERT_SVH
`define RADIX_INTEGER_TO_DIGITS_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define RID_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define RID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rid_pkg.sv */
// Package for the radix conversion block: widths, codes, state type and digit mapping.
package rid_pkg;

  localparam int unsigned DefaultMaxDigits = 64;
  localparam int unsigned DefaultValueBits = 64;

  localparam int unsigned ValueW = 64;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 7;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  localparam logic [BaseW-1:0] BaseMin = 6'd2;
  localparam logic [BaseW-1:0] BaseMax = 6'd36;
  localparam logic [BaseW-1:0] DecLimit = 6'd10;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharA    = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_BAD
  } state_e;

  // Map a digit value 0..35 to its ASCII character
  function automatic logic [CharW-1:0] digit_to_char(input logic [BaseW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DecLimit) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharA + CharW'(d - DecLimit);
    end
    return c;
  endfunction

endpackage

/* design/radix_integer_to_digits.sv */
// Radix conversion of an unsigned integer into a stream of ASCII digits.
//
// Slave stream: one transfer carries value (tdata[63:0]) and base (tdata[69:64]).
// Master stream: one transfer per digit, most significant first; tlast marks the
// least significant digit, tdata carries the character and the digit count, and
// tuser flags a base outside 2..36 (one transfer, character 0, count 1).
// Each digit comes from a bit-serial restoring divider by the base, one step per
// dividend bit; the characters are written to a digit memory and then read back
// in reverse order, each through a read state and a load state on the registered
// read port. A bad base skips the divider: its own state loads the lone transfer
// into the output register and returns the control to idle. Items are converted
// one at a time; s_axis_tready is high only while the control is idle, also while
// the final digit of the previous item still waits in the output register. A
// stalled receiver holds the output register and the read sequencer. Reset
// returns the control to idle and empties the output register; the digit memory
// needs no clearing, as only written entries are read.
`include "radix_integer_to_digits_assert.svh"

module radix_integer_to_digits #(
  parameter int unsigned MAX_DIGITS = rid_pkg::DefaultMaxDigits,
  parameter int unsigned VALUE_BITS = rid_pkg::DefaultValueBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // fields from bit 0: value[63:0], base[69:64], zero fill[71:70]
  input  logic [rid_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // fields from bit 0: digit_char[7:0], digit_count[14:8], zero fill[15]
  output logic [rid_pkg::OutDataW-1:0] m_axis_tdata,
  // fields from bit 0: bad_base[0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SW = $clog2(VALUE_BITS);
  localparam int unsigned BW = rid_pkg::BaseW;

  rid_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0]         val_q, val_d;
  logic [BW-1:0]                 rem_q, rem_d;
  logic [BW-1:0]                 base_q, base_d;
  logic [SW-1:0]                 step_q, step_d;
  logic [CW-1:0]                 n_q, n_d;
  logic [AW-1:0]                 rd_idx_q, rd_idx_d;

  logic                          mem_we, mem_re;
  logic [rid_pkg::CharW-1:0]     mem_wdata;
  logic [rid_pkg::CharW-1:0]     rdata_q;
  logic [rid_pkg::CharW-1:0]     mem [MAX_DIGITS];

  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic [rid_pkg::CharW-1:0]     out_char_q, out_char_d;
  logic [rid_pkg::CountW-1:0]    out_count_q, out_count_d;
  logic                          out_last_q, out_last_d;
  logic                          out_bad_q, out_bad_d;
  logic                          out_free;

  logic                          in_xfer;
  logic [rid_pkg::ValueW-1:0]    in_value;
  logic [BW-1:0]                 in_base;
  logic                          in_bad;

  logic [BW:0]                   rem_shift;
  logic                          qbit;
  logic [BW-1:0]                 rem_next;
  logic [VALUE_BITS-1:0]         val_next;
  logic [CW-1:0]                 n_inc;

  // Unpack the slave transfer
  assign in_value = s_axis_tdata[rid_pkg::ValueW-1:0];
  assign in_base  = s_axis_tdata[rid_pkg::ValueW +: BW];
  assign in_bad   = (in_base < rid_pkg::BaseMin) || (in_base > rid_pkg::BaseMax);

  assign s_axis_tready = (state_q == rid_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // One restoring division step: bring in the next dividend bit
  assign rem_shift = {rem_q, val_q[VALUE_BITS-1]};
  assign qbit      = (rem_shift >= {1'b0, base_q});
  assign rem_next  = qbit ? BW'(rem_shift - {1'b0, base_q}) : BW'(rem_shift);
  assign val_next  = {val_q[VALUE_BITS-2:0], qbit};
  assign n_inc     = n_q + CW'(1);
  assign mem_wdata = rid_pkg::digit_to_char(rem_next);

  // Next state, divider and read sequencer
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    rem_d       = rem_q;
    base_d      = base_q;
    step_d      = step_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    case (state_q)
      rid_pkg::ST_IDLE: begin
        if (in_xfer) begin
          val_d  = in_value[VALUE_BITS-1:0];
          base_d = in_base;
          rem_d  = '0;
          step_d = '0;
          n_d    = '0;
          state_d = in_bad ? rid_pkg::ST_BAD : rid_pkg::ST_DIV;
        end
      end
      rid_pkg::ST_DIV: begin
        val_d = val_next;
        rem_d = rem_next;
        step_d = step_q + SW'(1);
        if (step_q == SW'(VALUE_BITS - 1)) begin
          // Store the digit, then carry on with the quotient or read back
          mem_we = 1'b1;
          n_d    = n_inc;
          rem_d  = '0;
          step_d = '0;
          if ((val_next == '0) || (n_inc >= CW'(MAX_DIGITS))) begin
            rd_idx_d = n_q[AW-1:0];
            state_d  = rid_pkg::ST_READ;
          end
        end
      end
      rid_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = rid_pkg::ST_LOAD;
      end
      rid_pkg::ST_LOAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = rdata_q;
          out_count_d = rid_pkg::CountW'(n_q);
          out_last_d  = (rd_idx_q == '0);
          out_bad_d   = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = rid_pkg::ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - AW'(1);
            state_d  = rid_pkg::ST_READ;
          end
        end
      end
      rid_pkg::ST_BAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = '0;
          out_count_d = rid_pkg::CountW'(1);
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          state_d     = rid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rid_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the output register until the receiver takes it
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rid_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      n_q         <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      n_q         <= n_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    rem_q       <= rem_d;
    base_q      <= base_d;
    out_char_q  <= out_char_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    out_bad_q   <= out_bad_d;
  end

  // Digit memory: write on each finished division, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[n_q[AW-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  // Pack the master transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_char_q};

  `RID_ASSERT_IMP(a_bad_shape, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 16'h0100), "bad base transfer is not a lone zero digit")
  `RID_ASSERT_IMP(a_wr_in_range, mem_we, n_q < CW'(MAX_DIGITS), "digit write beyond memory depth")
  `RID_ASSERT_IMP(a_rd_in_range, state_q == rid_pkg::ST_LOAD, (CW'(rd_idx_q) < n_q) && (n_q != '0), "read back of an unwritten digit")
  `RID_ASSERT_NEXT(a_accept_start, in_xfer, (step_q == '0) && (n_q == '0) && ((state_q == rid_pkg::ST_DIV) || (state_q == rid_pkg::ST_BAD)), "accepted item did not start a conversion")
  `RID_ASSERT_IMP(a_char_alnum, m_axis_tvalid && !m_axis_tuser, ((m_axis_tdata[7:0] >= 8'h30) && (m_axis_tdata[7:0] <= 8'h39)) || ((m_axis_tdata[7:0] >= 8'h41) && (m_axis_tdata[7:0] <= 8'h5A)), "digit character out of range")

endmodule

/* test/tb.sv */
// Testbench for radix_integer_to_digits: directed table, random conversions, digit-stream checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 400;
  localparam int PhaseItems  = RandomItems / 4;
  // Worst case: every item a 64-digit binary conversion, each digit held back by a
  // long receiver stall, plus sender gaps; then margin.
  localparam int CycleLimit  = 20_000_000;
  localparam int DrainCycles = 200;
  localparam int ReportMax   = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_phase_e;

  // How a directed row gets its expected digits
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXT,
    CHK_BAD
  } check_e;

  typedef struct packed {
    logic [rid_pkg::CharW-1:0]  ch;
    logic                       last;
    logic [rid_pkg::CountW-1:0] count;
    logic                       bad;
  } digit_t;

  typedef struct {
    logic [rid_pkg::ValueW-1:0] value;
    logic [rid_pkg::BaseW-1:0]  base;
    check_e                     check;
    string                      text;
  } conv_row_t;

  localparam logic [rid_pkg::ValueW-1:0] AllOnes = {rid_pkg::ValueW{1'b1}};
  localparam int NumRows = 23;

  // Zero, digit boundaries, widest values, smallest and largest radix, bad radix
  conv_row_t conv_table [NumRows] = '{
    '{64'd0,                  6'd10, CHK_TEXT,  "0"},
    '{64'd0,                  6'd2,  CHK_TEXT,  "0"},
    '{64'd0,                  6'd36, CHK_TEXT,  "0"},
    '{64'd1,                  6'd2,  CHK_TEXT,  "1"},
    '{64'd9,                  6'd10, CHK_TEXT,  "9"},
    '{64'd10,                 6'd10, CHK_TEXT,  "10"},
    '{64'd10,                 6'd11, CHK_TEXT,  "A"},
    '{64'd35,                 6'd36, CHK_TEXT,  "Z"},
    '{64'd36,                 6'd36, CHK_TEXT,  "10"},
    '{64'd255,                6'd16, CHK_TEXT,  "FF"},
    '{AllOnes,                6'd16, CHK_TEXT,  "FFFFFFFFFFFFFFFF"},
    '{AllOnes,                6'd10, CHK_TEXT,  "18446744073709551615"},
    '{64'h0123_4567_89AB_CDEF, 6'd16, CHK_TEXT, "123456789ABCDEF"},
    '{AllOnes,                6'd2,  CHK_MODEL, ""},
    '{AllOnes,                6'd36, CHK_MODEL, ""},
    '{64'h8000_0000_0000_0000, 6'd2, CHK_MODEL, ""},
    '{64'hAAAA_AAAA_AAAA_AAAA, 6'd3, CHK_MODEL, ""},
    '{64'h5555_5555_5555_5555, 6'd35, CHK_MODEL, ""},
    '{64'd12345,              6'd7,  CHK_MODEL, ""},
    '{AllOnes,                6'd0,  CHK_BAD,   ""},
    '{64'd5,                  6'd1,  CHK_BAD,   ""},
    '{64'd0,                  6'd37, CHK_BAD,   ""},
    '{AllOnes,                6'd63, CHK_BAD,   ""}
  };

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic [rid_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [rid_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;

  digit_t pending_digits [$];
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     cycle_cnt      = 0;
  int     fail_cnt       = 0;
  int     items_sent     = 0;
  int     digits_seen    = 0;
  int     bad_seen       = 0;
  int     longest_run    = 0;

  radix_integer_to_digits i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d digits still expected",
               cycle_cnt, pending_digits.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Queue the digits of value in base, most significant first
  function automatic void expect_conversion(input logic [rid_pkg::ValueW-1:0] value,
                                            input logic [rid_pkg::BaseW-1:0] base);
    logic [rid_pkg::CharW-1:0] lsd_chars [64];
    logic [rid_pkg::ValueW-1:0] rest;
    logic [rid_pkg::ValueW-1:0] radix;
    logic [rid_pkg::ValueW-1:0] rem;
    int n;
    digit_t d;
    rest  = value;
    radix = rid_pkg::ValueW'(base);
    n     = 0;
    if (base < rid_pkg::BaseMin || base > rid_pkg::BaseMax) begin
      d = '{ch: '0, last: 1'b1, count: rid_pkg::CountW'(1), bad: 1'b1};
      pending_digits.push_back(d);
      return;
    end
    do begin
      rem = rest % radix;
      lsd_chars[n] = (rem < 10) ? rid_pkg::CharZero + rid_pkg::CharW'(rem)
                                : rid_pkg::CharA + rid_pkg::CharW'(rem - 10);
      rest = rest / radix;
      n++;
    end while (rest != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      d = '{ch: lsd_chars[n-1-k], last: (k == n - 1), count: rid_pkg::CountW'(n),
            bad: 1'b0};
      pending_digits.push_back(d);
    end
  endfunction

  // Queue a digit string typed into the table
  function automatic void expect_text(input string text);
    digit_t d;
    for (int k = 0; k < text.len(); k++) begin
      d = '{ch: text[k], last: (k == text.len() - 1),
            count: rid_pkg::CountW'(text.len()), bad: 1'b0};
      pending_digits.push_back(d);
    end
  endfunction

  // Present one conversion request and hold it until the transfer completes
  task automatic send_request(input logic [rid_pkg::ValueW-1:0] value,
                              input logic [rid_pkg::BaseW-1:0] base);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata  <= {2'b00, base, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Random value, mostly narrow to keep digit runs short
  function automatic logic [rid_pkg::ValueW-1:0] random_value();
    logic [rid_pkg::ValueW-1:0] full;
    int sel;
    int width;
    full = {$urandom(), $urandom()};
    sel  = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return AllOnes;
    if (sel < 60) width = $urandom_range(16, 1);
    else if (sel < 85) width = $urandom_range(40, 17);
    else width = 64;
    return (width == 64) ? full : full & ((rid_pkg::ValueW'(1) << width) - 1);
  endfunction

  // Random base: mostly valid, extremes favoured, some out of range
  function automatic logic [rid_pkg::BaseW-1:0] random_base();
    int sel;
    int r;
    sel = $urandom_range(99);
    if (sel < 10) begin
      r = $urandom_range(28);
      return (r < 2) ? rid_pkg::BaseW'(r) : rid_pkg::BaseW'(37 + r - 2);
    end
    if (sel < 35) begin
      case ($urandom_range(3))
        0: return rid_pkg::BaseMin;
        1: return 6'd10;
        2: return 6'd16;
        default: return rid_pkg::BaseMax;
      endcase
    end
    return rid_pkg::BaseW'($urandom_range(36, 2));
  endfunction

  // Check each digit transfer against the oldest expectation; drive back-pressure
  always @(posedge clk_i) begin
    digit_t got;
    digit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{ch: m_axis_tdata[7:0], last: m_axis_tlast,
              count: m_axis_tdata[14:8], bad: m_axis_tuser};
      digits_seen++;
      if (got.bad) bad_seen++;
      if (got.last && int'(got.count) > longest_run) longest_run = int'(got.count);
      if (pending_digits.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ReportMax)
          $display("%0t: unexpected digit ch=%h last=%b count=%0d bad=%b",
                   $realtime, got.ch, got.last, got.count, got.bad);
      end else begin
        want = pending_digits.pop_front();
        if (got != want) begin
          fail_cnt++;
          if (fail_cnt <= ReportMax)
            $display({"%0t: mismatch exp ch=%h last=%b count=%0d bad=%b, ",
                      "got ch=%h last=%b count=%0d bad=%b"},
                     $realtime, want.ch, want.last, want.count, want.bad,
                     got.ch, got.last, got.count, got.bad);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    idle_phase_e phase;
    logic [rid_pkg::ValueW-1:0] value;
    logic [rid_pkg::BaseW-1:0] base;

    // Hold reset, then release on a rising edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with no idling
    foreach (conv_table[i]) begin
      send_request(conv_table[i].value, conv_table[i].base);
      case (conv_table[i].check)
        CHK_TEXT: expect_text(conv_table[i].text);
        CHK_BAD:  expect_conversion(conv_table[i].value, conv_table[i].base);
        default:  expect_conversion(conv_table[i].value, conv_table[i].base);
      endcase
    end

    // Random conversions through each idling phase
    for (int i = 0; i < RandomItems; i++) begin
      phase = idle_phase_e'(i / PhaseItems);
      case (phase)
        IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default:   begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      value = random_value();
      base  = random_base();
      send_request(value, base);
      expect_conversion(value, base);
    end

    // Drop valid, drain the outstanding digits, then watch for stray transfers
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d requests (%0d from the table) into %0d digit transfers,",
             items_sent, NumRows, digits_seen);
    $display("%0d bad-radix rejections, longest run %0d digits, %0d failures",
             bad_seen, longest_run, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
